// ===== rtl/first_fit_span_allocator_macros.svh =====
// Assertion macros for the first-fit span allocator.
// Used by the top level only; no other dependencies.
`ifndef FIRST_FIT_SPAN_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SPAN_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("span allocator check failed");

// Next-cycle implication, checked outside reset.
`define FFSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("span allocator check failed");

`endif

// ===== rtl/ffsa_pkg.sv =====
// Shared widths, codes and controller/datapath interface types of the span allocator.
// No dependencies.
package ffsa_pkg;

   localparam int POS_W   = 17;   // span start, span length and pool size
   localparam int OFF_W   = 16;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int PTR_W   = 9;    // wide enough for any table index or count
   localparam int DEF_MAX_SPANS = 16;
   localparam int DEF_ADDR_BITS = 16;
   localparam logic [POS_W-1:0] POOL_RESET = 17'd65536;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

   localparam logic [1:0] WR_COPY = 2'd0;
   localparam logic [1:0] WR_NEW  = 2'd1;
   localparam logic [1:0] WR_LEN  = 2'd2;

   typedef struct packed {
      logic             accept;
      logic             scan_rd;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [1:0]       wr_sel;
      logic             cnt_inc;
      logic             cnt_dec;
      logic             latch_act;
      logic             load_rsp;
   } ctl_type;

   typedef struct packed {
      logic [PTR_W-1:0] count;
      logic             do_ins;
      logic             do_rem;
      logic             do_wlen;
      logic [PTR_W-1:0] ins_idx;
      logic [PTR_W-1:0] rem_idx;
      logic [PTR_W-1:0] wlen_idx;
   } sts_type;

   typedef struct packed {
      logic              do_ins;
      logic              do_rem;
      logic              do_wlen;
      logic [PTR_W-1:0]  ins_idx;
      logic [POS_W-1:0]  ins_start;
      logic [PTR_W-1:0]  rem_idx;
      logic [PTR_W-1:0]  wlen_idx;
      logic [STAT_W-1:0] status;
      logic [OFF_W-1:0]  roff;
      logic [POS_W-1:0]  rsize;
      logic              moved;
   } act_type;

endpackage

// ===== rtl/ffsa_datapath.sv =====
// Datapath of the span allocator: span table memory, scan evaluation, decision and result register.
// Depends on ffsa_pkg.
module ffsa_datapath #(
   parameter int MAX_SPANS = ffsa_pkg::DEF_MAX_SPANS,
   parameter int ADDR_BITS = ffsa_pkg::DEF_ADDR_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ffsa_pkg::ctl_type        ctl,
   output ffsa_pkg::sts_type        sts,
   input  logic [39:0]              req_tdata,
   input  logic [ffsa_pkg::POS_W-1:0] csr_data,
   input  logic                     csr_write,
   output logic [39:0]              rsp_tdata
);
   localparam int IW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
   localparam int CW = $clog2(MAX_SPANS + 1);
   localparam int PW = ffsa_pkg::POS_W;
   localparam int MW = 2 * PW;
   localparam logic [PW:0] CAP = (ADDR_BITS >= PW) ? {1'b0, {PW{1'b1}}} :
                                 ((PW+1)'(1) << ADDR_BITS);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SPANS);

   logic [MW-1:0] mem [MAX_SPANS];
   logic [MW-1:0] rdata_ff;
   logic          rvalid_ff;
   logic [IW-1:0] ridx_ff;

   logic [PW-1:0] pool_ff;
   logic [CW-1:0] cnt_ff;
   logic [ffsa_pkg::CMD_W-1:0] cmd_ff;
   logic [ffsa_pkg::OFF_W-1:0] off_ff;
   logic [PW-1:0] size_ff;

   logic          found_ff, hnext_ff, fit_ff;
   logic [IW-1:0] k_ff, fitidx_ff;
   logic [PW-1:0] klen_ff, nstart_ff;
   logic [PW:0]   fitpe_ff, pend_ff;

   ffsa_pkg::act_type act_in, act_ff;
   logic [39:0] rsp_ff;

   logic [PW-1:0] s_rd, l_rd, lim;
   logic [MW-1:0] wdata;

   assign s_rd = rdata_ff[MW-1:PW];
   assign l_rd = rdata_ff[PW-1:0];
   assign lim  = ({1'b0, pool_ff} < CAP) ? pool_ff : CAP[PW-1:0];

   always_comb begin
      case (ctl.wr_sel)
         ffsa_pkg::WR_NEW: wdata = {act_ff.ins_start, size_ff};
         ffsa_pkg::WR_LEN: wdata = {{(PW-ffsa_pkg::OFF_W){1'b0}}, off_ff, size_ff};
         default:          wdata = rdata_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[ctl.wr_addr[IW-1:0]] <= wdata;
      if (ctl.rd_en) rdata_ff <= mem[ctl.rd_addr[IW-1:0]];
      ridx_ff <= ctl.rd_addr[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff   <= ffsa_pkg::POOL_RESET;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= ctl.rd_en && ctl.scan_rd;
         if (csr_write) pool_ff <= csr_data;
         if (ctl.cnt_inc) cnt_ff <= cnt_ff + CW'(1);
         else if (ctl.cnt_dec) cnt_ff <= cnt_ff - CW'(1);
      end
   end

   // Scan evaluation: lookup of the offset, the entry after it, first fitting gap, last end.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff   <= req_tdata[1:0];
         off_ff   <= req_tdata[17:2];
         size_ff  <= req_tdata[34:18];
         found_ff <= 1'b0;
         hnext_ff <= 1'b0;
         fit_ff   <= 1'b0;
      end else if (rvalid_ff) begin
         if (!found_ff && s_rd == {1'b0, off_ff}) begin
            found_ff <= 1'b0 | 1'b1;
            k_ff     <= ridx_ff;
            klen_ff  <= l_rd;
         end
         if (found_ff && !hnext_ff && {1'b0, ridx_ff} == ({1'b0, k_ff} + (IW+1)'(1))) begin
            hnext_ff  <= 1'b1;
            nstart_ff <= s_rd;
         end
         if (ridx_ff != '0 && !fit_ff &&
             {2'b0, s_rd} >= ({1'b0, pend_ff} + {2'b0, size_ff})) begin
            fit_ff    <= 1'b1;
            fitidx_ff <= ridx_ff;
            fitpe_ff  <= pend_ff;
         end
         pend_ff <= {1'b0, s_rd} + {1'b0, l_rd};
      end
   end

   // Decision from the scan results.
   always_comb begin
      logic [ffsa_pkg::STAT_W-1:0] a_st;
      logic          a_ok;
      logic [CW-1:0] a_idx;
      logic [PW-1:0] a_start;
      logic [PW+1:0] grow_end;
      logic [PW-1:0] lim2;
      a_ok    = 1'b0;
      a_idx   = '0;
      a_start = '0;
      if (cnt_ff >= MAX_CNT) begin
         a_st = ffsa_pkg::ST_FULL;
      end else if (size_ff == '0) begin
         a_st = ffsa_pkg::ST_NOSPACE;
      end else if (cnt_ff == '0) begin
         a_st = (size_ff > lim) ? ffsa_pkg::ST_NOSPACE : ffsa_pkg::ST_OK;
         a_ok = (size_ff <= lim);
      end else if (fit_ff) begin
         a_st    = ffsa_pkg::ST_OK;
         a_ok    = 1'b1;
         a_idx   = CW'(fitidx_ff);
         a_start = fitpe_ff[PW-1:0];
      end else if (({1'b0, pend_ff} + {2'b0, size_ff}) <= {2'b0, lim}) begin
         a_st    = ffsa_pkg::ST_OK;
         a_ok    = 1'b1;
         a_idx   = cnt_ff;
         a_start = pend_ff[PW-1:0];
      end else begin
         a_st = ffsa_pkg::ST_NOSPACE;
      end
      lim2     = hnext_ff ? nstart_ff : lim;
      grow_end = {2'b0, off_ff} + {2'b0, size_ff};

      act_in           = '0;
      act_in.ins_idx   = ffsa_pkg::PTR_W'(a_idx);
      act_in.ins_start = a_start;
      act_in.rem_idx   = ffsa_pkg::PTR_W'(k_ff);
      act_in.wlen_idx  = ffsa_pkg::PTR_W'(k_ff);
      act_in.status    = ffsa_pkg::ST_OK;
      if (cmd_ff == ffsa_pkg::CMD_ALLOC || (cmd_ff == ffsa_pkg::CMD_REALLOC && !found_ff)) begin
         act_in.status = a_st;
         act_in.do_ins = a_ok;
         act_in.roff   = a_ok ? a_start[ffsa_pkg::OFF_W-1:0] : '0;
      end else if (!found_ff) begin
         act_in.status = ffsa_pkg::ST_NOTFOUND;
      end else if (cmd_ff == ffsa_pkg::CMD_FREE) begin
         act_in.do_rem = 1'b1;
      end else if (cmd_ff == ffsa_pkg::CMD_QUERY) begin
         act_in.roff  = off_ff;
         act_in.rsize = klen_ff;
      end else if (size_ff == '0) begin
         act_in.do_rem = 1'b1;
      end else if (size_ff <= klen_ff || grow_end <= {2'b0, lim2}) begin
         act_in.do_wlen = 1'b1;
         act_in.roff    = off_ff;
      end else begin
         // Move: insert the new span first, then drop the old one at its shifted index.
         act_in.status = a_st;
         if (a_ok) begin
            act_in.do_ins  = 1'b1;
            act_in.do_rem  = 1'b1;
            act_in.moved   = 1'b1;
            act_in.roff    = a_start[ffsa_pkg::OFF_W-1:0];
            act_in.rem_idx = (a_idx <= CW'(k_ff)) ? ffsa_pkg::PTR_W'(k_ff) + 1'b1 :
                                                    ffsa_pkg::PTR_W'(k_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch_act) act_ff <= act_in;
      if (ctl.load_rsp)
         rsp_ff <= {4'b0, act_ff.moved, act_ff.rsize, act_ff.roff, act_ff.status};
   end

   assign rsp_tdata    = rsp_ff;
   assign sts.count    = ffsa_pkg::PTR_W'(cnt_ff);
   assign sts.do_ins   = act_ff.do_ins;
   assign sts.do_rem   = act_ff.do_rem;
   assign sts.do_wlen  = act_ff.do_wlen;
   assign sts.ins_idx  = act_ff.ins_idx;
   assign sts.rem_idx  = act_ff.rem_idx;
   assign sts.wlen_idx = act_ff.wlen_idx;

endmodule

// ===== rtl/ffsa_controller.sv =====
// Controller state machine of the span allocator: scan, decide, shift and reply sequencing.
// Depends on ffsa_pkg.
module ffsa_controller #(
   parameter int MAX_SPANS = ffsa_pkg::DEF_MAX_SPANS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  ffsa_pkg::sts_type sts,
   output ffsa_pkg::ctl_type ctl
);
   localparam int CW = $clog2(MAX_SPANS + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SCAN    = 4'd1;
   localparam logic [3:0] S_DRAIN   = 4'd2;
   localparam logic [3:0] S_DECIDE  = 4'd3;
   localparam logic [3:0] S_DISP    = 4'd4;
   localparam logic [3:0] S_INS_RD  = 4'd5;
   localparam logic [3:0] S_INS_WR  = 4'd6;
   localparam logic [3:0] S_AFT_INS = 4'd7;
   localparam logic [3:0] S_REM_RD  = 4'd8;
   localparam logic [3:0] S_REM_WR  = 4'd9;
   localparam logic [3:0] S_WLEN    = 4'd10;
   localparam logic [3:0] S_DONE    = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] j_ff, j_in;
   logic          valid_ff, valid_in;
   logic [CW-1:0] cnt;

   assign cnt        = sts.count[CW-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      valid_in = valid_ff && !rsp_tready;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.accept = 1'b1;
               j_in       = '0;
               state_in   = (cnt == '0) ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.rd_en   = 1'b1;
            ctl.scan_rd = 1'b1;
            ctl.rd_addr = ffsa_pkg::PTR_W'(j_ff);
            j_in        = j_ff + CW'(1);
            if (j_ff + CW'(1) == cnt) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_DECIDE;
         S_DECIDE: begin
            ctl.latch_act = 1'b1;
            state_in      = S_DISP;
         end
         S_DISP: begin
            if (sts.do_ins) begin
               j_in     = cnt;
               state_in = S_INS_RD;
            end else if (sts.do_rem) begin
               j_in     = sts.rem_idx[CW-1:0] + CW'(1);
               state_in = S_REM_RD;
            end else if (sts.do_wlen) begin
               state_in = S_WLEN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_INS_RD: begin
            if (j_ff == sts.ins_idx[CW-1:0]) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_sel  = ffsa_pkg::WR_NEW;
               ctl.wr_addr = ffsa_pkg::PTR_W'(j_ff);
               ctl.cnt_inc = 1'b1;
               state_in    = S_AFT_INS;
            end else begin
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = ffsa_pkg::PTR_W'(j_ff - CW'(1));
               state_in    = S_INS_WR;
            end
         end
         S_INS_WR: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_sel  = ffsa_pkg::WR_COPY;
            ctl.wr_addr = ffsa_pkg::PTR_W'(j_ff);
            j_in        = j_ff - CW'(1);
            state_in    = S_INS_RD;
         end
         S_AFT_INS: begin
            if (sts.do_rem) begin
               j_in     = sts.rem_idx[CW-1:0] + CW'(1);
               state_in = S_REM_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_REM_RD: begin
            if (j_ff == cnt) begin
               ctl.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end else begin
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = ffsa_pkg::PTR_W'(j_ff);
               state_in    = S_REM_WR;
            end
         end
         S_REM_WR: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_sel  = ffsa_pkg::WR_COPY;
            ctl.wr_addr = ffsa_pkg::PTR_W'(j_ff - CW'(1));
            j_in        = j_ff + CW'(1);
            state_in    = S_REM_RD;
         end
         S_WLEN: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_sel  = ffsa_pkg::WR_LEN;
            ctl.wr_addr = sts.wlen_idx;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!valid_ff || rsp_tready) begin
               ctl.load_rsp = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         j_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/first_fit_span_allocator.sv =====
// Top level of the first-fit span allocator: controller and datapath with assertions.
// Depends on ffsa_pkg, ffsa_controller, ffsa_datapath and the assertion macro header.
//
// Usage: each request transaction on req_* carries a command (allocate, free,
// reallocate, query size), a span offset and a requested size. Exactly one
// response transaction on rsp_* follows per request, in order, with a status,
// the resulting offset, the queried size and a moved flag that tells software
// to copy the data of a relocated span.
// The pool size register is written over the csr_* channel, which is always
// ready; write it only while no request is in flight.
// With n spans in the table a request scans all n entries (one memory read per
// cycle), then shifts the table by one memory read and one write per moved
// entry; a move may shift twice. The duration of a request is set by the single
// read and write port of the span table memory.
// One request is processed at a time. A finished response is held in an output
// register, and the next request is accepted while it waits for rsp_tready;
// that request completes its work and then waits for the response register.
// Reset empties the table (the count is cleared, entries are not) and sets the
// pool size to 65536 bytes.
`include "first_fit_span_allocator_macros.svh"

module first_fit_span_allocator #(
   parameter int MAX_SPANS = ffsa_pkg::DEF_MAX_SPANS,
   parameter int ADDR_BITS = ffsa_pkg::DEF_ADDR_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // cmd[1:0], offset[17:2], size[34:18], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], result_offset[17:2],
                                    // result_size[34:18], moved[35], zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data     // pool_bytes
);
   ffsa_pkg::ctl_type ctl;
   ffsa_pkg::sts_type sts;

   // The pool register takes every write immediately.
   assign csr_ready = 1'b1;

   ffsa_controller #(.MAX_SPANS(MAX_SPANS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   ffsa_datapath #(.MAX_SPANS(MAX_SPANS), .ADDR_BITS(ADDR_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_tdata (req_tdata),
      .csr_data  (csr_data),
      .csr_write (csr_valid && csr_ready),
      .rsp_tdata (rsp_tdata)
   );

   // An accepted request makes the block busy in the next cycle.
   `FFSA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // The table never holds more spans than it has entries.
   `FFSA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, sts.count <= ffsa_pkg::PTR_W'(MAX_SPANS))
   // A moved span is only ever reported with an ok status.
   `FFSA_ASSERT_NOW(a_moved_ok, clock, reset, rsp_tvalid && rsp_tdata[35],
                    rsp_tdata[1:0] == ffsa_pkg::ST_OK)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the first-fit span allocator.
// Depends on ffsa_pkg and the first_fit_span_allocator top level.

// Scoreboard: keeps its own copy of the span table and the pool size, computes
// the expected response of every accepted request and checks responses in order.
class span_scoreboard;
   logic [16:0] pool_size;
   logic [16:0] tbl_start[16];
   logic [16:0] tbl_len[16];
   int          tbl_count;
   logic [35:0] pending[$];
   int          errors;

   function new();
      pool_size = ffsa_pkg::POOL_RESET;
      tbl_count = 0;
      errors = 0;
   endfunction

   function logic [16:0] pool_cap();
      return (pool_size > 17'd65536) ? 17'd65536 : pool_size;
   endfunction

   function int locate(logic [15:0] off);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_start[i] == {1'b0, off}) return i;
      return -1;
   endfunction

   function void put_span(int idx, logic [16:0] st, logic [16:0] len);
      for (int j = tbl_count; j > idx; j--) begin
         tbl_start[j] = tbl_start[j-1];
         tbl_len[j] = tbl_len[j-1];
      end
      tbl_start[idx] = st;
      tbl_len[idx] = len;
      tbl_count++;
   endfunction

   function void drop_span(int idx);
      for (int j = idx; j < tbl_count - 1; j++) begin
         tbl_start[j] = tbl_start[j+1];
         tbl_len[j] = tbl_len[j+1];
      end
      tbl_count--;
   endfunction

   // First-fit search; inter-span gaps first, then the tail.
   function logic [1:0] first_fit(logic [16:0] sz, output logic [16:0] st);
      longint pe, ns, e, pool;
      st = '0;
      pool = pool_cap();
      if (tbl_count >= 16) return ffsa_pkg::ST_FULL;
      if (sz == 0) return ffsa_pkg::ST_NOSPACE;
      if (tbl_count == 0) begin
         if (sz > pool) return ffsa_pkg::ST_NOSPACE;
         put_span(0, 17'd0, sz);
         return ffsa_pkg::ST_OK;
      end
      for (int i = 1; i < tbl_count; i++) begin
         pe = tbl_start[i-1] + tbl_len[i-1];
         ns = tbl_start[i];
         if (ns >= pe && ns - pe >= sz) begin
            put_span(i, pe[16:0], sz);
            st = pe[16:0];
            return ffsa_pkg::ST_OK;
         end
      end
      e = tbl_start[tbl_count-1] + tbl_len[tbl_count-1];
      if (e <= pool && pool - e >= sz) begin
         put_span(tbl_count, e[16:0], sz);
         st = e[16:0];
         return ffsa_pkg::ST_OK;
      end
      return ffsa_pkg::ST_NOSPACE;
   endfunction

   function void note_request(logic [1:0] cmd, logic [15:0] off, logic [16:0] sz);
      logic [1:0]  status;
      logic [16:0] roff, rsize, st;
      logic        moved;
      longint      lim;
      int          k;
      status = ffsa_pkg::ST_OK;
      roff = '0;
      rsize = '0;
      moved = 1'b0;
      k = locate(off);
      if (cmd == ffsa_pkg::CMD_ALLOC || (cmd == ffsa_pkg::CMD_REALLOC && k < 0)) begin
         status = first_fit(sz, st);
         if (status == ffsa_pkg::ST_OK) roff = st;
      end else if (cmd == ffsa_pkg::CMD_FREE) begin
         if (k < 0) status = ffsa_pkg::ST_NOTFOUND;
         else drop_span(k);
      end else if (cmd == ffsa_pkg::CMD_QUERY) begin
         if (k < 0) status = ffsa_pkg::ST_NOTFOUND;
         else begin
            roff = {1'b0, off};
            rsize = tbl_len[k];
         end
      end else if (sz == 0) begin
         drop_span(k);
      end else if (sz <= tbl_len[k]) begin
         tbl_len[k] = sz;
         roff = {1'b0, off};
      end else begin
         lim = (k + 1 < tbl_count) ? tbl_start[k+1] : pool_cap();
         if (longint'(tbl_start[k]) + sz <= lim) begin
            tbl_len[k] = sz;
            roff = {1'b0, off};
         end else begin
            status = first_fit(sz, st);
            if (status == ffsa_pkg::ST_OK) begin
               k = locate(off);
               if (k >= 0) drop_span(k);
               roff = st;
               moved = 1'b1;
            end
         end
      end
      pending.push_back({moved, rsize, roff[15:0], status});
   endfunction

   function void check_response(logic [39:0] data);
      logic [35:0] exp;
      if (pending.size() == 0) begin
         $error("unexpected response %h", data);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (data[1:0] !== exp[1:0]) begin
         $error("status: expected %0d, actual %0d", exp[1:0], data[1:0]);
         errors++;
      end
      if (data[17:2] !== exp[17:2]) begin
         $error("result_offset: expected %0d, actual %0d", exp[17:2], data[17:2]);
         errors++;
      end
      if (data[34:18] !== exp[34:18]) begin
         $error("result_size: expected %0d, actual %0d", exp[34:18], data[34:18]);
         errors++;
      end
      if (data[35] !== exp[35]) begin
         $error("moved: expected %0d, actual %0d", exp[35], data[35]);
         errors++;
      end
      if (data[39:36] !== 4'd0) begin
         $error("zero fill: expected 0, actual %0d", data[39:36]);
         errors++;
      end
   endfunction
endclass

module testbench;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [16:0] csr_data = '0;

   span_scoreboard board;
   bit          stimulus_done = 0;
   bit          hold_rsp = 0;    // long receiver hold-off in effect
   logic [15:0] live_offsets[$]; // offsets handed out, used to aim commands at real spans

   first_fit_span_allocator u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // Offer one request transaction and wait until it is accepted. The
   // scoreboard is updated at the accepting edge so that it stays in order.
   // The offer starts after the previous acceptance, never in its cycle; the
   // block is busy after an acceptance anyway.
   task automatic send_request(logic [1:0] cmd, logic [15:0] off, logic [16:0] sz,
                               bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      repeat (gap + 1) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, sz, off, cmd};
      do @(posedge clock); while (!req_tready);
      board.note_request(cmd, off, sz);
      req_tvalid <= 1'b0;
   endtask

   // Wait until every expected response has arrived, then let the block settle.
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write the pool size; only called while the block is idle.
   task automatic write_pool(logic [16:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.pool_size = value;
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stalls, plus the long hold-off when requested.
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else begin
            gap = pick_gap();
            if (gap != 0 && $urandom_range(0, 2) == 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
               if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus.
   initial begin
      logic [1:0]  cmd;
      logic [15:0] off;
      logic [16:0] sz;
      int r, phase_items;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero size, whole pool, table full, unknown offsets,
      // in-place shrink and grow, a forced move and realloc to zero.
      send_request(ffsa_pkg::CMD_ALLOC, 16'd0, 17'd0, 0);
      send_request(ffsa_pkg::CMD_ALLOC, 16'd0, 17'd65537, 0);
      send_request(ffsa_pkg::CMD_ALLOC, 16'hFFFF, 17'd65536, 0);
      send_request(ffsa_pkg::CMD_QUERY, 16'd0, 17'd0, 0);
      send_request(ffsa_pkg::CMD_FREE, 16'd0, 17'd0, 0);
      send_request(ffsa_pkg::CMD_FREE, 16'd0, 17'd0, 0);
      for (int i = 0; i < 17; i++)
         send_request(ffsa_pkg::CMD_ALLOC, 16'd0, 17'd100, 0);
      send_request(ffsa_pkg::CMD_REALLOC, 16'd100, 17'd50, 0);   // shrink in place
      send_request(ffsa_pkg::CMD_REALLOC, 16'd100, 17'd100, 0);  // grow into the gap
      send_request(ffsa_pkg::CMD_REALLOC, 16'd200, 17'd300, 0);  // move, table full
      send_request(ffsa_pkg::CMD_REALLOC, 16'd1500, 17'd64036, 0); // grow last to pool end
      send_request(ffsa_pkg::CMD_REALLOC, 16'd300, 17'd0, 0);    // frees
      send_request(ffsa_pkg::CMD_REALLOC, 16'd400, 17'd500, 0);  // move fails: no space
      send_request(ffsa_pkg::CMD_REALLOC, 16'd7, 17'd50, 0);     // unknown: acts as allocate
      send_request(ffsa_pkg::CMD_QUERY, 16'd400, 17'd0, 0);

      // Long receiver hold-off while requests keep coming, so the block backs up.
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 6; i++)
            send_request(ffsa_pkg::CMD_QUERY, 16'(i * 100), 17'd0, 1);
      join

      // Random phases, each with its own pool size; small pools bring out no
      // space and the shrunk-pool cases, the largest values the wide paths.
      for (int p = 0; p < 12; p++) begin
         case (p % 6)
            0: write_pool(17'd1);
            1: write_pool(17'd65536);
            2: write_pool(17'h1FFFF);
            3: write_pool(17'($urandom_range(16, 600)));
            4: write_pool(17'($urandom_range(1, 131071)));
            default: write_pool(17'($urandom_range(2000, 65535)));
         endcase
         phase_items = 95;
         for (int n = 0; n < phase_items; n++) begin
            r = $urandom_range(0, 99);
            cmd = 2'($urandom_range(0, 3));
            if (r < 75 && live_offsets.size() != 0 && cmd != ffsa_pkg::CMD_ALLOC)
               off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
            else
               off = 16'($urandom());
            r = $urandom_range(0, 99);
            if (r < 60) sz = 17'($urandom_range(0, 64));
            else if (r < 85) sz = 17'($urandom_range(0, 4096));
            else sz = 17'($urandom_range(0, 131071));
            send_request(cmd, off, sz, 1);
            // Track span starts from the scoreboard copy of the table.
            live_offsets.delete();
            for (int i = 0; i < board.tbl_count; i++)
               live_offsets.push_back(board.tbl_start[i][15:0]);
         end
      end
      drain();
      repeat (100) @(posedge clock);
      stimulus_done = 1;
   end

   // Final verdict.
   initial begin
      wait (stimulus_done);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS first_fit_span_allocator");
      end else begin
         $display("FAIL first_fit_span_allocator");
      end
      $finish;
   end

   // Timeout well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("FAIL first_fit_span_allocator");
      $finish;
   end
endmodule
